/* design/lpcp_pkg.sv */
// ----------------------------------------------------------------------------
// Line pair closest points: shared package
// Constants shared by the top level and the partial-product multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcp_pkg;

	// Width of one limb of a multi-cycle multiplication.
	localparam int LIMB_W = 32;

	// Width and reset value of the parallel threshold register.
	localparam int THR_W = 32;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd43;

endpackage

`default_nettype wire

/* design/lpcp_mul.sv */
// ----------------------------------------------------------------------------
// Line pair closest points: pipelined signed multiplier
// Sign and magnitude are split in the first stage, then one limb-by-limb
// partial product is added per stage, and the sign is restored at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	import lpcp_pkg::*;

	localparam int LA    = (AW + LIMB_W - 1) / LIMB_W;
	localparam int LB    = (BW + LIMB_W - 1) / LIMB_W;
	localparam int NP    = LA * LB;
	localparam int AMW   = LA * LIMB_W;
	localparam int BMW   = LB * LIMB_W;
	localparam int PW    = (LA + LB) * LIMB_W;
	localparam int PRODW = AW + BW;

	logic [AW-1:0]         a_mag;
	logic [BW-1:0]         b_mag;
	logic [AMW-1:0]        am_s [NP];
	logic [BMW-1:0]        bm_s [NP];
	logic [PW-1:0]         acc_s [NP+1];
	logic                  neg_s [NP+1];
	logic [2*LIMB_W-1:0]   pp [NP];
	logic [PRODW-1:0]      mag_fin;

	assign a_mag   = a[AW-1] ? AW'(-a) : AW'(a);
	assign b_mag   = b[BW-1] ? BW'(-b) : BW'(b);
	assign mag_fin = acc_s[NP][PRODW-1:0];

	// Each stage multiplies one limb of a by one limb of b.
	always_comb begin
		for (int k = 0; k < NP; k++) begin
			pp[k] = am_s[k][(k / LB)*LIMB_W +: LIMB_W] * bm_s[k][(k % LB)*LIMB_W +: LIMB_W];
		end
	end

	always_ff @(posedge clk) begin
		am_s[0]  <= AMW'(a_mag);
		bm_s[0]  <= BMW'(b_mag);
		acc_s[0] <= '0;
		neg_s[0] <= a[AW-1] ^ b[BW-1];
		for (int k = 1; k < NP; k++) begin
			am_s[k] <= am_s[k-1];
			bm_s[k] <= bm_s[k-1];
		end
		for (int k = 0; k < NP; k++) begin
			acc_s[k+1] <= acc_s[k] + (PW'(pp[k]) << (((k / LB) + (k % LB)) * LIMB_W));
			neg_s[k+1] <= neg_s[k];
		end
		p <= neg_s[NP] ? $signed(PRODW'(-mag_fin)) : $signed(mag_fin);
	end

endmodule

`default_nettype wire

/* design/lpcp_div.sv */
// ----------------------------------------------------------------------------
// Line pair closest points: pipelined rounding divider
// Signed quotient rounded to nearest, ties away from zero, saturated to QW
// bits, with one quotient bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_div #(
	parameter int NW = 149,
	parameter int DW = 133,
	parameter int QW = 32
) (
	input  logic                 clk,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic signed [QW-1:0] quo,
	output logic                 fault
);
	localparam int XW  = NW + 1;
	localparam int DXW = DW + 1;
	localparam int HW  = XW - QW;
	localparam int CW  = (HW > DXW) ? HW : DXW;
	localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

	typedef struct packed {
		logic ovf;
		logic qneg;
		logic nneg;
		logic nzero;
		logic dzero;
	} div_flags_t;

	logic [NW-1:0]  nm_s1;
	logic [DW-1:0]  dm_s1;
	div_flags_t     fl_s1;
	logic [XW-1:0]  nx_s2;
	logic [DXW-1:0] dx_s2;
	div_flags_t     fl_s2;

	logic [DXW-1:0] r_it   [QW+1];
	logic [QW-1:0]  q_it   [QW+1];
	logic [QW-1:0]  nlo_it [QW+1];
	logic [DXW-1:0] dx_it  [QW+1];
	div_flags_t     fl_it  [QW+1];

	logic [DXW:0]   trial  [QW];
	logic           ge     [QW];
	logic [QW-1:0]  qv;
	logic           big;

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			trial[k] = {r_it[k], nlo_it[k][QW-1-k]};
			ge[k]    = trial[k] >= {1'b0, dx_it[k]};
		end
	end

	assign qv  = q_it[QW];
	assign big = fl_it[QW].qneg ? (qv[QW-1] && (|qv[QW-2:0])) : qv[QW-1];

	always_ff @(posedge clk) begin
		nm_s1       <= num[NW-1] ? NW'(-num) : NW'(num);
		dm_s1       <= den[DW-1] ? DW'(-den) : DW'(den);
		fl_s1.ovf   <= 1'b0;
		fl_s1.qneg  <= num[NW-1] ^ den[DW-1];
		fl_s1.nneg  <= num[NW-1];
		fl_s1.nzero <= (num == '0);
		fl_s1.dzero <= (den == '0);

		// Round to nearest: floor((2|n| + |d|) / (2|d|)).
		nx_s2 <= (XW'(nm_s1) << 1) + XW'(dm_s1);
		dx_s2 <= DXW'(dm_s1) << 1;
		fl_s2 <= fl_s1;

		r_it[0]       <= DXW'(nx_s2 >> QW);
		q_it[0]       <= '0;
		nlo_it[0]     <= nx_s2[QW-1:0];
		dx_it[0]      <= dx_s2;
		fl_it[0]      <= '{ovf:   CW'(nx_s2 >> QW) >= CW'(dx_s2),
		                   qneg:  fl_s2.qneg,
		                   nneg:  fl_s2.nneg,
		                   nzero: fl_s2.nzero,
		                   dzero: fl_s2.dzero};

		for (int k = 0; k < QW; k++) begin
			r_it[k+1]   <= ge[k] ? DXW'(trial[k] - {1'b0, dx_it[k]}) : DXW'(trial[k]);
			q_it[k+1]   <= {q_it[k][QW-2:0], ge[k]};
			nlo_it[k+1] <= nlo_it[k];
			dx_it[k+1]  <= dx_it[k];
			fl_it[k+1]  <= fl_it[k];
		end

		if (fl_it[QW].dzero) begin
			fault <= 1'b1;
			if (fl_it[QW].nzero) begin
				quo <= '0;
			end else begin
				quo <= fl_it[QW].nneg ? QMIN : QMAX;
			end
		end else begin
			fault <= 1'b0;
			if (fl_it[QW].ovf || big) begin
				quo <= fl_it[QW].qneg ? QMIN : QMAX;
			end else begin
				quo <= fl_it[QW].qneg ? $signed(QW'(-qv)) : $signed(qv);
			end
		end
	end

endmodule

`default_nettype wire

/* design/line_pair_closest_points.sv */
// ----------------------------------------------------------------------------
// Line pair closest points
// Closest points between two lines in the plane, signed fixed point, one
// line pair accepted per clock in a free-running pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Beat contents
//  -------   ----------------------   ------------------------------------------
//  input     start (busy always low)  two origins and two directions
//  config    cfg_valid / cfg_ready    parallel threshold, Q0.32 on |det|
//  result    done (one-cycle strobe)  s, t, both closest points, two flags
//
// A beat is accepted on every cycle that start is high, since busy is held
// low. Every beat gives exactly one result beat, at a delay set by the
// limb-serial multipliers and the one bit per stage divider. The pipeline
// has no back-pressure and never stalls; the receiver must take every
// result, which the block itself does not enforce. Reset clears the valid
// chain and sets the threshold to 43; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pair_closest_points #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lpcp_pkg::THR_W-1:0]    cfg_data,
	input  logic signed [COORD_WIDTH-1:0] first_origin_x,
	input  logic signed [COORD_WIDTH-1:0] first_origin_y,
	input  logic signed [COORD_WIDTH-1:0] first_dir_x,
	input  logic signed [COORD_WIDTH-1:0] first_dir_y,
	input  logic signed [COORD_WIDTH-1:0] second_origin_x,
	input  logic signed [COORD_WIDTH-1:0] second_origin_y,
	input  logic signed [COORD_WIDTH-1:0] second_dir_x,
	input  logic signed [COORD_WIDTH-1:0] second_dir_y,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] first_param,
	output logic signed [COORD_WIDTH-1:0] second_param,
	output logic signed [COORD_WIDTH-1:0] near_first_x,
	output logic signed [COORD_WIDTH-1:0] near_first_y,
	output logic signed [COORD_WIDTH-1:0] near_second_x,
	output logic signed [COORD_WIDTH-1:0] near_second_y,
	output logic                          is_parallel,
	output logic                          divide_fault
);
	import lpcp_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int F = FRAC_BITS;

	// Widths: dot products of (W+1)-bit terms, then products of dot products.
	localparam int DOTW = 2 * (W + 1) + 1;
	localparam int PRW  = 2 * DOTW + 1;
	localparam int NW   = PRW + F;
	localparam int DW   = PRW;
	localparam int TW   = 2 * W + F + 1;
	localparam int CMPW = PRW + THR_W + 4 * F + 1;

	// Multiplier latencies follow from the number of limbs on each side; the divider's from the quotient width.
	localparam int LA1   = (W + 1 + LIMB_W - 1) / LIMB_W;
	localparam int LB1   = (DOTW + LIMB_W - 1) / LIMB_W;
	localparam int LC1   = (W + LIMB_W - 1) / LIMB_W;
	localparam int LAT_A = LA1 * LA1 + 2;
	localparam int LAT_B = LB1 * LB1 + 2;
	localparam int LAT_C = LC1 * LC1 + 2;
	localparam int LAT_D = W + 4;

	// Distance from the input register to the divider outputs.
	localparam int D_PT  = LAT_A + 1 + LAT_B + 3 + LAT_D;
	localparam int D_P   = D_PT + LAT_C;
	localparam int D_ACD = LAT_B + 2;
	localparam int NV    = D_PT + LAT_C + 3;
	localparam int LAT   = NV + 1;

	localparam logic signed [W-1:0] SMAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN  = {1'b1, {(W-1){1'b0}}};
	localparam logic [TW-1:0]       HALFW = TW'(1) << (W - 1);
	localparam logic [TW-1:0]       HALFF = TW'(1) << (F - 1);

	// Threshold register and control.
	logic [THR_W-1:0] thr_q;
	logic             vld_s1;
	logic             vld_dl [NV];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = vld_dl[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RESET;
			vld_s1 <= 1'b0;
			for (int i = 0; i < NV; i++) begin
				vld_dl[i] <= 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			vld_s1    <= start && !busy;
			vld_dl[0] <= vld_s1;
			for (int i = 1; i < NV; i++) begin
				vld_dl[i] <= vld_dl[i-1];
			end
		end
	end

	// Stage 1: input register. Origins are kept in the order first x, first
	// y, second x, second y; directions likewise. The offset w = p1 - p2 is
	// formed here at one bit more than a coordinate.
	logic signed [W-1:0] p_s1   [4];
	logic signed [W-1:0] dir_s1 [4];
	logic signed [W:0]   wx_s1;
	logic signed [W:0]   wy_s1;

	always_ff @(posedge clk) begin
		p_s1[0]   <= first_origin_x;
		p_s1[1]   <= first_origin_y;
		p_s1[2]   <= second_origin_x;
		p_s1[3]   <= second_origin_y;
		dir_s1[0] <= first_dir_x;
		dir_s1[1] <= first_dir_y;
		dir_s1[2] <= second_dir_x;
		dir_s1[3] <= second_dir_y;
		wx_s1     <= (W+1)'(first_origin_x) - (W+1)'(second_origin_x);
		wy_s1     <= (W+1)'(first_origin_y) - (W+1)'(second_origin_y);
	end

	// Ten products for the five dot products a = u.w, b = u.u, c = u.v,
	// d = v.w and f = v.v.
	logic signed [W:0]     opa_a  [10];
	logic signed [W:0]     opb_a  [10];
	logic signed [2*W+1:0] prod_a [10];

	always_comb begin
		opa_a[0] = (W+1)'(dir_s1[0]); opb_a[0] = wx_s1;
		opa_a[1] = (W+1)'(dir_s1[1]); opb_a[1] = wy_s1;
		opa_a[2] = (W+1)'(dir_s1[0]); opb_a[2] = (W+1)'(dir_s1[0]);
		opa_a[3] = (W+1)'(dir_s1[1]); opb_a[3] = (W+1)'(dir_s1[1]);
		opa_a[4] = (W+1)'(dir_s1[0]); opb_a[4] = (W+1)'(dir_s1[2]);
		opa_a[5] = (W+1)'(dir_s1[1]); opb_a[5] = (W+1)'(dir_s1[3]);
		opa_a[6] = (W+1)'(dir_s1[2]); opb_a[6] = wx_s1;
		opa_a[7] = (W+1)'(dir_s1[3]); opb_a[7] = wy_s1;
		opa_a[8] = (W+1)'(dir_s1[2]); opb_a[8] = (W+1)'(dir_s1[2]);
		opa_a[9] = (W+1)'(dir_s1[3]); opb_a[9] = (W+1)'(dir_s1[3]);
	end

	for (genvar i = 0; i < 10; i++) begin : g_mul_dot
		lpcp_mul #(.AW(W + 1), .BW(W + 1)) u_mul (
			.clk (clk),
			.a   (opa_a[i]),
			.b   (opb_a[i]),
			.p   (prod_a[i])
		);
	end

	// Stage 2: the dot products themselves.
	logic signed [DOTW-1:0] a_s2, b_s2, c_s2, d_s2, f_s2;

	always_ff @(posedge clk) begin
		a_s2 <= DOTW'(prod_a[0]) + DOTW'(prod_a[1]);
		b_s2 <= DOTW'(prod_a[2]) + DOTW'(prod_a[3]);
		c_s2 <= DOTW'(prod_a[4]) + DOTW'(prod_a[5]);
		d_s2 <= DOTW'(prod_a[6]) + DOTW'(prod_a[7]);
		f_s2 <= DOTW'(prod_a[8]) + DOTW'(prod_a[9]);
	end

	// Products of dot products: f*b, c*c, b*d, a*c, c*d and f*a.
	logic signed [DOTW-1:0]   opa_b  [6];
	logic signed [DOTW-1:0]   opb_b  [6];
	logic signed [2*DOTW-1:0] prod_b [6];

	always_comb begin
		opa_b[0] = f_s2; opb_b[0] = b_s2;
		opa_b[1] = c_s2; opb_b[1] = c_s2;
		opa_b[2] = b_s2; opb_b[2] = d_s2;
		opa_b[3] = a_s2; opb_b[3] = c_s2;
		opa_b[4] = c_s2; opb_b[4] = d_s2;
		opa_b[5] = f_s2; opb_b[5] = a_s2;
	end

	for (genvar i = 0; i < 6; i++) begin : g_mul_det
		lpcp_mul #(.AW(DOTW), .BW(DOTW)) u_mul (
			.clk (clk),
			.a   (opa_b[i]),
			.b   (opb_b[i]),
			.p   (prod_b[i])
		);
	end

	// a, c and d wait here for the parallel case, which divides by c.
	logic signed [DOTW-1:0] acd_dl [D_ACD][3];

	always_ff @(posedge clk) begin
		acd_dl[0][0] <= a_s2;
		acd_dl[0][1] <= c_s2;
		acd_dl[0][2] <= d_s2;
		for (int i = 1; i < D_ACD; i++) begin
			acd_dl[i] <= acd_dl[i-1];
		end
	end

	// Stage 3: determinant and the two general-case numerators.
	logic signed [PRW-1:0] dt_s3, nt_s3, ns_s3;

	always_ff @(posedge clk) begin
		dt_s3 <= PRW'(prod_b[0]) - PRW'(prod_b[1]);
		nt_s3 <= PRW'(prod_b[2]) - PRW'(prod_b[3]);
		ns_s3 <= PRW'(prod_b[4]) - PRW'(prod_b[5]);
	end

	// Stage 4: the parallel test, |dt| * 2^32 < threshold * 2^(4F). A zero
	// threshold never marks a pair as parallel.
	logic [PRW-1:0]        dt_mag;
	logic                  par_s4;
	logic signed [PRW-1:0] dt_s4, nt_s4, ns_s4;

	assign dt_mag = dt_s3[PRW-1] ? PRW'(-dt_s3) : PRW'(dt_s3);

	always_ff @(posedge clk) begin
		par_s4 <= (CMPW'(dt_mag) << THR_W) < (CMPW'(thr_q) << (4 * F));
		dt_s4  <= dt_s3;
		nt_s4  <= nt_s3;
		ns_s4  <= ns_s3;
	end

	// Stage 5: choose numerators and divisor. Parallel lines use s = -d/c and
	// t = a/c; otherwise both parameters come from the determinant.
	logic signed [DOTW:0]   d_neg;
	logic signed [NW-1:0]   num_s_s5, num_t_s5;
	logic signed [DW-1:0]   den_s5;
	logic                   par_s5;

	assign d_neg = -((DOTW+1)'(acd_dl[D_ACD-1][2]));

	always_ff @(posedge clk) begin
		par_s5 <= par_s4;
		if (par_s4) begin
			num_s_s5 <= NW'(d_neg) << F;
			num_t_s5 <= NW'(acd_dl[D_ACD-1][0]) << F;
			den_s5   <= DW'(acd_dl[D_ACD-1][1]);
		end else begin
			num_s_s5 <= NW'(ns_s4) << F;
			num_t_s5 <= NW'(nt_s4) << F;
			den_s5   <= dt_s4;
		end
	end

	// The two divisions share a divisor, so either fault flag would do; both
	// are combined to keep the meaning plain.
	logic signed [W-1:0] s_div, t_div;
	logic                fault_s, fault_t;

	lpcp_div #(.NW(NW), .DW(DW), .QW(W)) u_div_s (
		.clk   (clk),
		.num   (num_s_s5),
		.den   (den_s5),
		.quo   (s_div),
		.fault (fault_s)
	);

	lpcp_div #(.NW(NW), .DW(DW), .QW(W)) u_div_t (
		.clk   (clk),
		.num   (num_t_s5),
		.den   (den_s5),
		.quo   (t_div),
		.fault (fault_t)
	);

	// Side data delayed to meet the divider and multiplier outputs.
	logic                par_dl [LAT_D];
	logic signed [W-1:0] dir_dl [D_PT][4];
	logic signed [W-1:0] p_dl   [D_P][4];

	always_ff @(posedge clk) begin
		par_dl[0] <= par_s5;
		for (int i = 1; i < LAT_D; i++) begin
			par_dl[i] <= par_dl[i-1];
		end
		dir_dl[0] <= dir_s1;
		for (int i = 1; i < D_PT; i++) begin
			dir_dl[i] <= dir_dl[i-1];
		end
		p_dl[0] <= p_s1;
		for (int i = 1; i < D_P; i++) begin
			p_dl[i] <= p_dl[i-1];
		end
	end

	// Points along the lines: s*u for the first line, t*v for the second.
	logic signed [W-1:0]   opa_c  [4];
	logic signed [W-1:0]   opb_c  [4];
	logic signed [2*W-1:0] prod_c [4];

	always_comb begin
		opa_c[0] = s_div;
		opa_c[1] = s_div;
		opa_c[2] = t_div;
		opa_c[3] = t_div;
		for (int i = 0; i < 4; i++) begin
			opb_c[i] = dir_dl[D_PT-1][i];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_mul_pt
		lpcp_mul #(.AW(W), .BW(W)) u_mul (
			.clk (clk),
			.a   (opa_c[i]),
			.b   (opb_c[i]),
			.p   (prod_c[i])
		);
	end

	// Parameters and flags wait for the point products.
	logic signed [W-1:0] prm_dl [LAT_C][2];
	logic [1:0]          flg_dl [LAT_C];

	always_ff @(posedge clk) begin
		prm_dl[0][0] <= s_div;
		prm_dl[0][1] <= t_div;
		flg_dl[0]    <= {par_dl[LAT_D-1], fault_s | fault_t};
		for (int i = 1; i < LAT_C; i++) begin
			prm_dl[i] <= prm_dl[i-1];
			flg_dl[i] <= flg_dl[i-1];
		end
	end

	// Stage 6: p * 2^F + prm * dir, exact.
	logic signed [TW-1:0] tot_s6 [4];
	logic signed [W-1:0]  prm_s6 [2];
	logic [1:0]           flg_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			tot_s6[i] <= (TW'(p_dl[D_P-1][i]) << F) + TW'(prod_c[i]);
		end
		prm_s6 <= prm_dl[LAT_C-1];
		flg_s6 <= flg_dl[LAT_C-1];
	end

	// Stage 7: scale back by 2^F, rounding the magnitude half away from zero.
	logic [TW-1:0]       tot_mag [4];
	logic [TW-1:0]       rmag_s7 [4];
	logic                rneg_s7 [4];
	logic signed [W-1:0] prm_s7  [2];
	logic [1:0]          flg_s7;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tot_mag[i] = tot_s6[i][TW-1] ? TW'(-tot_s6[i]) : TW'(tot_s6[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			rmag_s7[i] <= (tot_mag[i] + HALFF) >> F;
			rneg_s7[i] <= tot_s6[i][TW-1];
		end
		prm_s7 <= prm_s6;
		flg_s7 <= flg_s6;
	end

	// Output register with saturation to the coordinate range.
	logic signed [W-1:0] sat_val [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (rneg_s7[i]) begin
				sat_val[i] = (rmag_s7[i] > HALFW) ? SMIN : $signed(W'(-rmag_s7[i]));
			end else begin
				sat_val[i] = (rmag_s7[i] >= HALFW) ? SMAX : $signed(W'(rmag_s7[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		first_param   <= prm_s7[0];
		second_param  <= prm_s7[1];
		near_first_x  <= sat_val[0];
		near_first_y  <= sat_val[1];
		near_second_x <= sat_val[2];
		near_second_y <= sat_val[3];
		is_parallel   <= flg_s7[1];
		divide_fault  <= flg_s7[0];
	end

	// Every accepted beat is matched by a done strobe at the end of the pipeline.
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing at fixed latency");

	// A zero divisor drives both parameters to a rail or to zero.
	a_fault_value : assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_fault) |->
		((first_param == SMAX || first_param == SMIN || first_param == '0) &&
		 (second_param == SMAX || second_param == SMIN || second_param == '0)))
		else $error("divide fault with an unsaturated parameter");

	// Outside the parallel case a zero determinant is only possible when the
	// threshold is zero.
	a_fault_general : assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_fault && !is_parallel) |-> (thr_q == '0))
		else $error("general-case divide fault with non-zero threshold");

	// A configuration beat lands in the threshold register.
	a_cfg_write : assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (thr_q == $past(cfg_data)))
		else $error("threshold write lost");

endmodule

`default_nettype wire

/* test/line_pair_closest_points_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line pair closest points: testbench
// Drives line pairs through the command port, predicts every result with an
// exact wide-integer model of the closest-point solution, and checks each
// result beat field by field. The threshold register is swept between phases.
// ----------------------------------------------------------------------------

module line_pair_closest_points_tb;

	localparam int FRAC = 16;
	localparam int CW   = 32;
	localparam int LAT  = 64;

	typedef logic signed [CW-1:0]  coord_t;
	typedef logic signed [255:0]   wide_t;

	typedef struct {
		coord_t p1x, p1y, ux, uy, p2x, p2y, vx, vy;
	} line_pair_t;

	typedef struct {
		coord_t s, t, q1x, q1y, q2x, q2y;
		logic   par, fault;
	} closest_t;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [lpcp_pkg::THR_W-1:0] cfg_data;
	line_pair_t drv;
	closest_t   got;

	line_pair_t pending_pairs[$];
	closest_t   expected_points[$];
	logic [lpcp_pkg::THR_W-1:0] threshold;
	int  idle_pct;
	int  errors;
	bit  beat_taken;

	line_pair_closest_points #(.FRAC_BITS(FRAC), .COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.first_origin_x(drv.p1x), .first_origin_y(drv.p1y),
		.first_dir_x(drv.ux), .first_dir_y(drv.uy),
		.second_origin_x(drv.p2x), .second_origin_y(drv.p2y),
		.second_dir_x(drv.vx), .second_dir_y(drv.vy),
		.done(done), .first_param(got.s), .second_param(got.t),
		.near_first_x(got.q1x), .near_first_y(got.q1y),
		.near_second_x(got.q2x), .near_second_y(got.q2y),
		.is_parallel(got.par), .divide_fault(got.fault)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Rounded division, ties away from zero, saturated to the coordinate
	// range. A zero divisor saturates by the sign of the numerator, or gives zero for a zero numerator.
	function automatic coord_t round_div_sat(wide_t num, wide_t den, inout bit fault);
		wide_t mn, md, q, lim;
		bit neg;
		if (den == 0) begin
			fault = 1'b1;
			if (num == 0) return '0;
			return num < 0 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end
		neg = (num < 0) != (den < 0);
		mn  = num < 0 ? -num : num;
		md  = den < 0 ? -den : den;
		q   = ((mn <<< 1) + md) / (md <<< 1);
		lim = neg ? (wide_t'(1) <<< (CW-1)) : (wide_t'(1) <<< (CW-1)) - 1;
		if (q > lim) return neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		return neg ? coord_t'(-q) : coord_t'(q);
	endfunction

	// A point along a line, origin plus parameter times direction.
	function automatic coord_t point_along(coord_t p, coord_t prm, coord_t dir);
		wide_t o, m, d;
		bit ignored;
		o = p;
		m = prm;
		d = dir;
		ignored = 1'b0;
		return round_div_sat((o <<< FRAC) + m * d, wide_t'(1) <<< FRAC, ignored);
	endfunction

	function automatic closest_t solve_closest(line_pair_t lp);
		wide_t ux, uy, vx, vy, wx, wy, a, b, c, d, f, det, mag;
		closest_t r;
		bit fault;
		ux  = lp.ux;  uy = lp.uy;  vx = lp.vx;  vy = lp.vy;
		wx  = wide_t'(lp.p1x) - wide_t'(lp.p2x);
		wy  = wide_t'(lp.p1y) - wide_t'(lp.p2y);
		a   = ux * wx + uy * wy;
		b   = ux * ux + uy * uy;
		c   = ux * vx + uy * vy;
		d   = vx * wx + vy * wy;
		f   = vx * vx + vy * vy;
		det = f * b - c * c;
		mag = det < 0 ? -det : det;
		fault = 1'b0;
		// Parallel when |det| in Q64.64 terms sits under the Q0.32 threshold.
		r.par = mag < (wide_t'({1'b0, threshold}) <<< 32);
		if (r.par) begin
			r.s = round_div_sat((-d) <<< FRAC, c, fault);
			r.t = round_div_sat(a <<< FRAC, c, fault);
		end else begin
			r.t = round_div_sat((b * d - a * c) <<< FRAC, det, fault);
			r.s = round_div_sat((c * d - f * a) <<< FRAC, det, fault);
		end
		r.fault = fault;
		r.q1x = point_along(lp.p1x, r.s, lp.ux);
		r.q1y = point_along(lp.p1y, r.s, lp.uy);
		r.q2x = point_along(lp.p2x, r.t, lp.vx);
		r.q2y = point_along(lp.p2y, r.t, lp.vy);
		return r;
	endfunction

	// Driver: a beat that has not yet been taken is held; otherwise the next
	// pair is offered unless this cycle is chosen to be idle.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			drv   <= '{default: '0};
		end else if (start && !beat_taken) begin
			start <= 1'b1;
		end else if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
			start <= 1'b1;
			drv   <= pending_pairs.pop_front();
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: records accepted beats as expectations and checks results.
	always @(posedge clk) begin
		closest_t e;
		beat_taken = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				beat_taken = 1'b1;
				expected_points.push_back(solve_closest(drv));
			end
			if (done) begin
				if (expected_points.size() == 0) begin
					$display("%0t: result with no pair outstanding, got s=%h t=%h",
						$time, got.s, got.t);
					errors++;
				end else begin
					e = expected_points.pop_front();
					if (e != got) begin
						$display("%0t: mismatch expected s=%h t=%h p1=%h,%h p2=%h,%h par=%b flt=%b",
							$time, e.s, e.t, e.q1x, e.q1y, e.q2x, e.q2y, e.par, e.fault);
						$display("%0t:          actual s=%h t=%h p1=%h,%h p2=%h,%h par=%b flt=%b",
							$time, got.s, got.t, got.q1x, got.q1y, got.q2x, got.q2y,
							got.par, got.fault);
						errors++;
					end
				end
			end
		end
	end

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t rand_near(int span);
		return coord_t'(int'($urandom_range(2 * span)) - span);
	endfunction

	// A mix of fully random pairs, pairs of modest size, and
	// parallel or nearly parallel pairs that exercise the threshold.
	function automatic line_pair_t random_pair();
		line_pair_t lp;
		int k, kind;
		kind = $urandom_range(9);
		if (kind < 3) begin
			lp = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord()};
		end else begin
			lp = '{rand_near(1 << 22), rand_near(1 << 22), rand_near(1 << 18),
				rand_near(1 << 18), rand_near(1 << 22), rand_near(1 << 22),
				rand_near(1 << 18), rand_near(1 << 18)};
			if (kind >= 7) begin
				k = int'($urandom_range(8)) - 4;
				lp.vx = lp.ux * k + (kind == 9 ? rand_near(1) : 0);
				lp.vy = lp.uy * k;
			end
		end
		return lp;
	endfunction

	task automatic write_threshold(logic [lpcp_pkg::THR_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		threshold = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Lets every outstanding pair come back, then stays quiet for longer than the pipeline latency.
	task automatic drain_pipeline();
		while (pending_pairs.size() > 0 || start || expected_points.size() > 0)
			@(posedge clk);
		repeat (LAT + 8) @(posedge clk);
	endtask

	task automatic random_phase(int count, int pct);
		idle_pct = pct;
		repeat (count) pending_pairs.push_back(random_pair());
		drain_pipeline();
	endtask

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t ONE  = 1 <<< FRAC;

	initial begin
		errors    = 0;
		idle_pct  = 0;
		threshold = lpcp_pkg::THRESHOLD_RESET;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pairs at the reset threshold: all zero (parallel with a
		// zero divisor), crossing axes, parallel and identical lines, a zero
		// direction on one line, and the coordinate extremes.
		pending_pairs.push_back('{default: '0});
		pending_pairs.push_back('{0, 0, ONE, 0, 0, ONE, 0, ONE});
		pending_pairs.push_back('{ONE, 2 * ONE, ONE, ONE, -ONE, 3 * ONE, -ONE, ONE});
		pending_pairs.push_back('{0, 0, ONE, 0, 0, ONE, 2 * ONE, 0});
		pending_pairs.push_back('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
		pending_pairs.push_back('{0, 0, ONE, ONE, 5 * ONE, 0, 0, 0});
		pending_pairs.push_back('{ONE, 0, 0, 0, 0, ONE, ONE, 0});
		pending_pairs.push_back('{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN});
		pending_pairs.push_back('{CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX});
		pending_pairs.push_back('{CMAX, CMIN, 1, 0, CMIN, CMAX, 0, 1});
		pending_pairs.push_back('{CMIN, CMIN, CMIN, 0, CMAX, CMAX, 0, CMIN});
		pending_pairs.push_back('{0, 0, 1, 1, 3, -2, -1, 1});
		pending_pairs.push_back('{-ONE, -ONE, -1, 0, ONE, ONE, 1, 0});
		pending_pairs.push_back('{0, 0, ONE, 0, 0, ONE, ONE, 1});
		pending_pairs.push_back('{-1, -1, -1, -1, -1, -1, -1, 1});
		drain_pipeline();

		// Threshold zero: nothing counts as parallel, so parallel lines
		// reach the general solution with a zero determinant.
		write_threshold('0);
		pending_pairs.push_back('{default: '0});
		pending_pairs.push_back('{0, 0, ONE, 0, 0, ONE, 2 * ONE, 0});
		pending_pairs.push_back('{0, 0, ONE, ONE, ONE, 0, -ONE, ONE});
		pending_pairs.push_back('{ONE, 0, 0, 0, 0, ONE, ONE, 0});
		random_phase(150, 0);

		// Largest threshold: any pair with |det| below the largest Q0.32 value counts as parallel.
		write_threshold('1);
		random_phase(150, 81);

		write_threshold(lpcp_pkg::THRESHOLD_RESET);
		random_phase(200, 0);

		write_threshold($urandom);
		random_phase(150, 21);

		write_threshold($urandom_range(1 << 20));
		random_phase(150, 81);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
